FILE: sv/erc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package erc_pkg;

  // Field and register widths
  localparam int CountW    = 16;
  localparam int TrigW     = 16;
  localparam int DivisorW  = 16;
  localparam int ClockW    = 27;
  localparam int MaxDistW  = 15;
  localparam int DistW     = 16;
  localparam int ScaleW    = 27;
  localparam int ProdW     = CountW + ScaleW;
  localparam int StepW     = $clog2(ProdW + 1);
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 27;

  // Final scaling constant
  localparam logic [ScaleW-1:0] Scale = ScaleW'(100000000);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TRIGGER_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ECHO_DIVISOR  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLOCK_HZ      = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DISTANCE  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [TrigW-1:0]    RstTriggerTicks = TrigW'(20);
  localparam logic [DivisorW-1:0] RstEchoDivisor  = DivisorW'(58);
  localparam logic [ClockW-1:0]   RstClockHz      = ClockW'(16000000);
  localparam logic [MaxDistW-1:0] RstMaxDistance  = MaxDistW'(4000);

  // Input command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic cmd;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic                    start_accepted;
    logic                    trigger_out;
    logic                    busy_res;
    logic                    done_res;
    logic signed [DistW-1:0] distance;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic step;   // apply a simple item and load the result
    logic div1;   // start count / echo_divisor
    logic mul;    // register quotient * scale
    logic div2;   // start product / clock_hz
    logic fin;    // close the measurement and load the result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic needs_calc;
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: sv/erc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left-aligned into the quotient shift register; after N steps the low N
// bits hold the quotient.
module erc_div (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  input  wire  [erc_pkg::ProdW-1:0]           q_init,
  input  wire  [erc_pkg::ClockW-1:0]          divisor,
  input  wire  [erc_pkg::StepW-1:0]           steps,
  output logic [erc_pkg::ProdW-1:0]           quot,
  output logic                                done
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [erc_pkg::StepW-1:0]   cnt_r, cnt_nxt;
  logic [erc_pkg::ProdW-1:0]   q_r, q_nxt;
  logic [erc_pkg::ClockW-1:0]  rem_r, rem_nxt;
  logic [erc_pkg::ClockW-1:0]  dvs_r, dvs_nxt;
  logic [erc_pkg::ClockW:0]    rem_ext;
  logic                        fits;

  // One shift-subtract step
  always_comb begin
    rem_ext = {rem_r, q_r[erc_pkg::ProdW-1]};
    fits    = (rem_ext >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      q_nxt    = q_init;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[erc_pkg::ProdW-2:0], fits};
      rem_nxt = fits ? erc_pkg::ClockW'(rem_ext - {1'b0, dvs_r})
                     : rem_ext[erc_pkg::ClockW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == erc_pkg::StepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quot = q_r;
  assign done = done_r;

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy)
    else $error("divider done without a running division");

  property p_no_restart_busy;
    @(posedge clk) disable iff (!rst_n) busy_r |-> !start;
  endproperty
  a_no_restart_busy: assert property (p_no_restart_busy)
    else $error("divider restarted while busy");

  property p_rem_below_divisor;
    @(posedge clk) disable iff (!rst_n) (busy_r && !$rose(busy_r)) |-> (rem_r < dvs_r);
  endproperty
  a_rem_below_divisor: assert property (p_rem_below_divisor)
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

FILE: sv/erc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Datapath: configuration registers, ranging phase, tick counters, the
// shared divider, the scaling multiplier and the result register.
module erc_dp (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire  [erc_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire  [erc_pkg::CfgDataW-1:0]    cfg_data,
  input  erc_pkg::in_item_t               in_data,
  input  erc_pkg::ctrl_cmd_t              cmd,
  output erc_pkg::dp_sts_t                sts,
  output erc_pkg::out_item_t              out_data
);

  typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_MEAS} phase_t;

  logic [erc_pkg::TrigW-1:0]    trig_ticks_r;
  logic [erc_pkg::DivisorW-1:0] echo_div_r;
  logic [erc_pkg::ClockW-1:0]   clock_hz_r;
  logic [erc_pkg::MaxDistW-1:0] max_dist_r;

  phase_t                       phase_r, phase_nxt;
  logic [erc_pkg::TrigW-1:0]    trig_cnt_r, trig_cnt_nxt;
  logic [erc_pkg::CountW-1:0]   echo_cnt_r, echo_cnt_nxt;
  logic [erc_pkg::DistW-1:0]    last_dist_r, last_dist_nxt;
  logic [erc_pkg::ProdW-1:0]    prod_r;
  erc_pkg::out_item_t           out_r, out_nxt;

  logic [erc_pkg::TrigW-1:0]    trig_inc, trig_lim;
  logic [erc_pkg::ClockW-1:0]   div1_dvs, div2_dvs;
  logic                         div_start;
  logic [erc_pkg::ProdW-1:0]    div_q_init;
  logic [erc_pkg::ClockW-1:0]   div_dvs;
  logic [erc_pkg::StepW-1:0]    div_steps;
  logic [erc_pkg::ProdW-1:0]    quot;
  logic                         div_done;
  logic [erc_pkg::DistW-1:0]    fin_dist;
  logic                         accepted, done;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r <= erc_pkg::RstTriggerTicks;
      echo_div_r   <= erc_pkg::RstEchoDivisor;
      clock_hz_r   <= erc_pkg::RstClockHz;
      max_dist_r   <= erc_pkg::RstMaxDistance;
    end else if (cfg_we) begin
      unique case (cfg_index)
        erc_pkg::CFG_TRIGGER_TICKS: trig_ticks_r <= cfg_data[erc_pkg::TrigW-1:0];
        erc_pkg::CFG_ECHO_DIVISOR:  echo_div_r   <= cfg_data[erc_pkg::DivisorW-1:0];
        erc_pkg::CFG_CLOCK_HZ:      clock_hz_r   <= cfg_data[erc_pkg::ClockW-1:0];
        erc_pkg::CFG_MAX_DISTANCE:  max_dist_r   <= cfg_data[erc_pkg::MaxDistW-1:0];
        default: ;
      endcase
    end
  end

  // Zero limits and divisors act as one
  always_comb begin
    trig_inc = trig_cnt_r + 1'b1;
    trig_lim = (trig_ticks_r == '0) ? erc_pkg::TrigW'(1) : trig_ticks_r;
    div1_dvs = (echo_div_r == '0) ? erc_pkg::ClockW'(1)
                                  : erc_pkg::ClockW'(echo_div_r);
    div2_dvs = (clock_hz_r == '0) ? erc_pkg::ClockW'(1) : clock_hz_r;
  end

  // Shared divider: count / echo_divisor, then product / clock_hz
  always_comb begin
    div_start = cmd.div1 | cmd.div2;
    if (cmd.div1) begin
      div_q_init = {echo_cnt_r, {(erc_pkg::ProdW-erc_pkg::CountW){1'b0}}};
      div_dvs    = div1_dvs;
      div_steps  = erc_pkg::StepW'(erc_pkg::CountW);
    end else begin
      div_q_init = prod_r;
      div_dvs    = div2_dvs;
      div_steps  = erc_pkg::StepW'(erc_pkg::ProdW);
    end
  end

  erc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .q_init  (div_q_init),
    .divisor (div_dvs),
    .steps   (div_steps),
    .quot    (quot),
    .done    (div_done)
  );

  // Scale the first quotient
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= quot[erc_pkg::CountW-1:0] * erc_pkg::Scale;
    end
  end

  // Range check on the full-width quotient
  assign fin_dist = (quot > erc_pkg::ProdW'(max_dist_r)) ? '1 : quot[erc_pkg::DistW-1:0];

  // Phase and counter update for one item or for the close of a measurement
  always_comb begin
    phase_nxt     = phase_r;
    trig_cnt_nxt  = trig_cnt_r;
    echo_cnt_nxt  = echo_cnt_r;
    last_dist_nxt = last_dist_r;
    accepted      = 1'b0;
    done          = 1'b0;
    if (cmd.step) begin
      if (in_data.cmd == erc_pkg::CMD_START) begin
        if (phase_r == PH_IDLE) begin
          accepted     = 1'b1;
          phase_nxt    = PH_TRIG;
          trig_cnt_nxt = '0;
          echo_cnt_nxt = '0;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_TRIG: begin
            trig_cnt_nxt = trig_inc;
            if (trig_inc >= trig_lim) phase_nxt = PH_WAIT;
          end
          PH_WAIT: begin
            if (in_data.echo_level) begin
              echo_cnt_nxt = '0;
              phase_nxt    = PH_MEAS;
            end
          end
          PH_MEAS: begin
            // falling echo goes through the divider path, not here
            if (echo_cnt_r == '1) begin
              echo_cnt_nxt  = '0;
              last_dist_nxt = '1;
              phase_nxt     = PH_IDLE;
              done          = 1'b1;
            end else begin
              echo_cnt_nxt = echo_cnt_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end else if (cmd.fin) begin
      last_dist_nxt = fin_dist;
      phase_nxt     = PH_IDLE;
      done          = 1'b1;
    end
  end

  always_comb begin
    out_nxt.start_accepted = accepted;
    out_nxt.trigger_out    = (phase_nxt == PH_TRIG);
    out_nxt.busy_res       = (phase_nxt != PH_IDLE);
    out_nxt.done_res       = done;
    out_nxt.distance       = last_dist_nxt;
  end

  // Ranging state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      trig_cnt_r  <= '0;
      echo_cnt_r  <= '0;
      last_dist_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      trig_cnt_r  <= trig_cnt_nxt;
      echo_cnt_r  <= echo_cnt_nxt;
      last_dist_r <= last_dist_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.step || cmd.fin) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // Status to the controller
  always_comb begin
    sts.needs_calc = (in_data.cmd == erc_pkg::CMD_TICK) && (phase_r == PH_MEAS) &&
                     !in_data.echo_level;
    sts.div_done   = div_done;
  end

  property p_fin_in_meas;
    @(posedge clk) disable iff (!rst_n) cmd.fin |-> (phase_r == PH_MEAS);
  endproperty
  a_fin_in_meas: assert property (p_fin_in_meas)
    else $error("measurement closed outside the measure phase");

  property p_calc_keeps_phase;
    @(posedge clk) disable iff (!rst_n) (cmd.div1 || cmd.mul || cmd.div2) |=> $stable(phase_r);
  endproperty
  a_calc_keeps_phase: assert property (p_calc_keeps_phase)
    else $error("phase moved during distance calculation");

  property p_calc_from_meas;
    @(posedge clk) disable iff (!rst_n) cmd.div1 |-> (phase_r == PH_MEAS);
  endproperty
  a_calc_from_meas: assert property (p_calc_from_meas)
    else $error("distance calculation started outside the measure phase");

endmodule

`default_nettype wire

FILE: sv/erc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Controller: input and result handshakes, and sequencing of the
// distance calculation on the datapath.
module erc_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire                   out_stall,
  input  erc_pkg::dp_sts_t      sts,
  output erc_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {C_READY, C_DIV1, C_MUL, C_DIV2, C_FIN} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  // Result slot is free if empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == C_READY) && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.step = accept && !sts.needs_calc;
    cmd.div1 = accept && sts.needs_calc;
    cmd.mul  = (state_r == C_DIV1) && sts.div_done;
    cmd.div2 = (state_r == C_MUL);
    cmd.fin  = (state_r == C_FIN) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_READY: if (cmd.div1) state_nxt = C_DIV1;
      C_DIV1:  if (sts.div_done) state_nxt = C_MUL;
      C_MUL:   state_nxt = C_DIV2;
      C_DIV2:  if (sts.div_done) state_nxt = C_FIN;
      C_FIN:   if (out_free) state_nxt = C_READY;
      default: state_nxt = C_READY;
    endcase
    out_valid_nxt = (cmd.step || cmd.fin) ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_READY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  property p_cmd_onehot;
    @(posedge clk) disable iff (!rst_n) $onehot0(cmd);
  endproperty
  a_cmd_onehot: assert property (p_cmd_onehot)
    else $error("more than one datapath command at once");

  property p_load_when_free;
    @(posedge clk) disable iff (!rst_n) (cmd.step || cmd.fin) |-> out_free;
  endproperty
  a_load_when_free: assert property (p_load_when_free)
    else $error("result loaded over a waiting beat");

  property p_div_done_expected;
    @(posedge clk) disable iff (!rst_n)
      sts.div_done |-> (state_r == C_DIV1 || state_r == C_DIV2);
  endproperty
  a_div_done_expected: assert property (p_div_done_expected)
    else $error("divider finished outside a divide state");

endmodule

`default_nettype wire

FILE: sv/ultrasonic_echo_ranger_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Ultrasonic echo ranging controller. Each input beat is either a start
// request or one timer tick with the sampled echo level; every input beat
// yields exactly one result beat with trigger level, busy and done flags and
// the last distance (-1 for no obstacle or counter overflow). The tick that
// sees the falling echo starts the distance calculation: a bit-serial
// restoring divider produces one quotient bit per cycle, 16 bits for count /
// echo_divisor, then 43 bits for the scaled product / clock_hz, with the
// scaling multiplier between the two divisions. While a result beat waits on
// out_stall, no further input beat is taken. Configuration writes are always
// ready and should be issued only while no measurement result is pending.
module ultrasonic_echo_ranger_core (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  erc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output erc_pkg::out_item_t             out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [erc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire  [erc_pkg::CfgDataW-1:0]   cfg_data
);

  erc_pkg::ctrl_cmd_t cmd;
  erc_pkg::dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  erc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  erc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
